// File: src/audio_frame_ring_fifo_defines.svh
// assertion macros for the audio frame ring fifo
// no dependencies; included by the top level
`ifndef AUDIO_FRAME_RING_FIFO_DEFINES_SVH
`define AUDIO_FRAME_RING_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define AFRF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("afrf assertion failed");

// next-cycle implication, checked outside reset
`define AFRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("afrf assertion failed");

`else

`define AFRF_ASSERT_NOW(label, clk, rstn, ante, cons)
`define AFRF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: src/afrf_pkg.sv
// shared types, constants and helper functions for the audio frame ring fifo
// no dependencies
package afrf_pkg;

    localparam int DEPTH      = 1024;
    localparam int MAX_BURST  = 64;
    localparam int FRAME_BITS = 64;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int LEVEL_W = 10;
    localparam int COUNT_W = 7;
    localparam int FRAME_W = 64;
    localparam int CAP_W   = 4;
    localparam int CAP_MAX = (PTR_W < 10) ? PTR_W : 10;
    localparam int CMP_W   = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

    // result queue between the memory stage and the output port
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        KIND_WR_REQ  = 2'd0,
        KIND_WR_DATA = 2'd1,
        KIND_RD_REQ  = 2'd2,
        KIND_FLUSH   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [COUNT_W-1:0] granted;
        logic [FRAME_W-1:0] frame;
        logic               frame_valid;
        logic               last;
        logic [LEVEL_W-1:0] fill_level;
        logic [LEVEL_W-1:0] free_space;
    } result_t;

    // ring index mask from the capacity register, clamped to the legal range
    function automatic logic [PTR_W-1:0] mask_of(input logic [CAP_W-1:0] lg_in);
        logic [CAP_W-1:0] lg;
        lg = lg_in;
        if (lg < CAP_W'(1)) lg = CAP_W'(1);
        if (lg > CAP_W'(CAP_MAX)) lg = CAP_W'(CAP_MAX);
        return PTR_W'((1 << lg) - 1);
    endfunction

    // grant for a request against the frames available
    function automatic logic [COUNT_W-1:0] grant_of(input logic [PTR_W-1:0] avail,
                                                    input logic [COUNT_W-1:0] count,
                                                    input logic partial);
        logic [COUNT_W-1:0] want;
        logic [CMP_W-1:0]   want_x;
        logic [CMP_W-1:0]   avail_x;
        want    = (count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : count;
        want_x  = CMP_W'(want);
        avail_x = CMP_W'(avail);
        if (want == '0 || avail == '0) return '0;
        if (avail_x < want_x && !partial) return '0;
        return (avail_x < want_x) ? COUNT_W'(avail_x) : want;
    endfunction

endpackage

// File: src/afrf_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module afrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/audio_frame_ring_fifo.sv
// top level of the audio frame ring fifo: pointer control, read bursts, result queue
// depends on afrf_pkg, afrf_ram and audio_frame_ring_fifo_defines.svh

// Ring FIFO of packed audio frames held in one ram with a registered read port.
// Write requests, write data words and flushes each give one result word. A read
// request granting g frames gives g result words and holds the input until all g
// ram reads are issued, one ram read per cycle while the result queue has room; a
// zero grant gives one word. Every result passes one ram-latency stage and then a
// 4-word result queue, so the input keeps moving while a finished word waits at
// the output. Outside a read burst the input stalls only when the queue cannot
// take another word or a configuration write is waiting. Writing the capacity
// register clears both pointers and any pending write grant. Frames in slots
// never written read back as unknown data.
`include "audio_frame_ring_fifo_defines.svh"

module audio_frame_ring_fifo (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [afrf_pkg::CAP_W-1:0]             cfg_data,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_kind,
    input  logic [afrf_pkg::COUNT_W-1:0]           s_count,
    input  logic                                   s_allow_partial,
    input  logic [afrf_pkg::FRAME_W-1:0]           s_frame_in,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [afrf_pkg::COUNT_W-1:0]           m_granted,
    output logic [afrf_pkg::FRAME_W-1:0]           m_frame_out,
    output logic                                   m_frame_valid,
    output logic                                   m_last,
    output logic [afrf_pkg::LEVEL_W-1:0]           m_fill_level,
    output logic [afrf_pkg::LEVEL_W-1:0]           m_free_space
);

    localparam int PTR_W   = afrf_pkg::PTR_W;
    localparam int COUNT_W = afrf_pkg::COUNT_W;
    localparam int LEVEL_W = afrf_pkg::LEVEL_W;
    localparam int OQ_AW   = afrf_pkg::OQ_AW;

    // ring control state
    logic [PTR_W-1:0]   mask_reg, mask_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [COUNT_W-1:0] pending_reg, pending_next;

    // read burst state
    logic               burst_active_reg, burst_active_next;
    logic [COUNT_W-1:0] burst_left_reg, burst_left_next;
    logic [PTR_W-1:0]   burst_addr_reg, burst_addr_next;
    logic [COUNT_W-1:0] burst_g_reg, burst_g_next;

    // ram-latency stage
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_read_reg, s1_read_next;
    afrf_pkg::result_t   s1_res_reg, s1_res_next;

    // result queue
    afrf_pkg::result_t   q_reg [afrf_pkg::OQ_DEPTH];
    logic [OQ_AW-1:0]    head_reg, head_next;
    logic [OQ_AW-1:0]    tail_reg, tail_next;
    logic [OQ_AW:0]      cnt_reg, cnt_next;
    afrf_pkg::result_t   push_res;
    afrf_pkg::result_t   head_res;
    logic                push, pop;
    logic [OQ_AW+1:0]    room_sum;
    logic                issue_ok;

    // ram ports
    logic                               ram_we;
    logic                               ram_re;
    logic [PTR_W-1:0]                   ram_raddr;
    logic [afrf_pkg::FRAME_BITS-1:0]    ram_rdata;

    logic [PTR_W-1:0]   fill_now, free_now;
    logic [PTR_W-1:0]   fill_after;
    logic [COUNT_W-1:0] grant;
    logic               s_accept, cfg_accept;
    afrf_pkg::kind_t    kind;

    assign kind       = afrf_pkg::kind_t'(s_kind);
    assign fill_now   = (wp_reg - rp_reg) & mask_reg;
    assign free_now   = mask_reg - fill_now;

    // issue only while the queue can take the word already in flight plus one more
    assign room_sum   = (OQ_AW+2)'(cnt_reg) + (OQ_AW+2)'(s1_valid_reg);
    assign issue_ok   = room_sum < (OQ_AW+2)'(afrf_pkg::OQ_DEPTH);

    assign cfg_ready  = !burst_active_reg;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_ready    = !burst_active_reg && issue_ok && !cfg_valid;
    assign s_accept   = s_valid && s_ready;

    // grant against free space for writes, fill level for reads
    assign grant = afrf_pkg::grant_of((kind == afrf_pkg::KIND_RD_REQ) ? fill_now : free_now,
                                      s_count, s_allow_partial);

    // pointer, burst and stage-one next state
    always_comb begin
        mask_next         = mask_reg;
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        pending_next      = pending_reg;
        burst_active_next = burst_active_reg;
        burst_left_next   = burst_left_reg;
        burst_addr_next   = burst_addr_reg;
        burst_g_next      = burst_g_reg;
        s1_valid_next     = 1'b0;
        s1_read_next      = 1'b0;
        s1_res_next       = '0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = burst_addr_reg;
        fill_after        = '0;

        if (cfg_accept) begin
            mask_next    = afrf_pkg::mask_of(cfg_data);
            wp_next      = '0;
            rp_next      = '0;
            pending_next = '0;
        end else if (burst_active_reg) begin
            // later beats of a read burst, pointers already moved
            if (issue_ok) begin
                ram_re                  = 1'b1;
                s1_valid_next           = 1'b1;
                s1_read_next            = 1'b1;
                s1_res_next.granted     = burst_g_reg;
                s1_res_next.frame_valid = 1'b1;
                s1_res_next.last        = (burst_left_reg == COUNT_W'(1));
                s1_res_next.fill_level  = LEVEL_W'(fill_now);
                s1_res_next.free_space  = LEVEL_W'(free_now);
                burst_left_next         = burst_left_reg - COUNT_W'(1);
                burst_addr_next         = (burst_addr_reg + PTR_W'(1)) & mask_reg;
                burst_active_next       = (burst_left_reg != COUNT_W'(1));
            end
        end else if (s_accept) begin
            s1_valid_next    = 1'b1;
            s1_res_next.last = 1'b1;
            unique case (kind)
                afrf_pkg::KIND_WR_REQ: begin
                    pending_next        = grant;
                    s1_res_next.granted = grant;
                end
                afrf_pkg::KIND_WR_DATA: begin
                    if (pending_reg != '0) begin
                        ram_we       = 1'b1;
                        wp_next      = (wp_reg + PTR_W'(1)) & mask_reg;
                        pending_next = pending_reg - COUNT_W'(1);
                    end
                end
                afrf_pkg::KIND_RD_REQ: begin
                    if (grant != '0) begin
                        // first beat goes out with the request
                        ram_re                  = 1'b1;
                        ram_raddr               = rp_reg;
                        s1_read_next            = 1'b1;
                        s1_res_next.granted     = grant;
                        s1_res_next.frame_valid = 1'b1;
                        s1_res_next.last        = (grant == COUNT_W'(1));
                        rp_next                 = (rp_reg + PTR_W'(grant)) & mask_reg;
                        burst_g_next            = grant;
                        burst_left_next         = grant - COUNT_W'(1);
                        burst_addr_next         = (rp_reg + PTR_W'(1)) & mask_reg;
                        burst_active_next       = (grant != COUNT_W'(1));
                    end
                end
                afrf_pkg::KIND_FLUSH: begin
                    wp_next      = '0;
                    rp_next      = '0;
                    pending_next = '0;
                end
            endcase
            fill_after             = (wp_next - rp_next) & mask_reg;
            s1_res_next.fill_level = LEVEL_W'(fill_after);
            s1_res_next.free_space = LEVEL_W'(mask_reg - fill_after);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg         <= afrf_pkg::mask_of(afrf_pkg::CAP_RESET);
            wp_reg           <= '0;
            rp_reg           <= '0;
            pending_reg      <= '0;
            burst_active_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end else begin
            mask_reg         <= mask_next;
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            pending_reg      <= pending_next;
            burst_active_reg <= burst_active_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    // burst and stage-one payload
    always_ff @(posedge aclk) begin
        burst_left_reg <= burst_left_next;
        burst_addr_reg <= burst_addr_next;
        burst_g_reg    <= burst_g_next;
        s1_read_reg    <= s1_read_next;
        s1_res_reg     <= s1_res_next;
    end

    // frame store
    afrf_ram #(
        .WIDTH (afrf_pkg::FRAME_BITS),
        .DEPTH (afrf_pkg::DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (s_frame_in[afrf_pkg::FRAME_BITS-1:0]),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // stage-one word joins the frame read from the ram
    always_comb begin
        push_res       = s1_res_reg;
        push_res.frame = s1_read_reg ? afrf_pkg::FRAME_W'(ram_rdata) : '0;
    end

    assign push     = s1_valid_reg;
    assign pop      = m_valid && m_ready;
    assign head_res = q_reg[head_reg];

    // result queue pointers
    always_comb begin
        head_next = pop ? head_reg + OQ_AW'(1) : head_reg;
        tail_next = push ? tail_reg + OQ_AW'(1) : tail_reg;
        cnt_next  = cnt_reg + (OQ_AW+1)'(push) - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[tail_reg] <= push_res;
        end
    end

    // output word
    assign m_valid       = (cnt_reg != '0);
    assign m_granted     = head_res.granted;
    assign m_frame_out   = head_res.frame;
    assign m_frame_valid = head_res.frame_valid;
    assign m_last        = head_res.last;
    assign m_fill_level  = head_res.fill_level;
    assign m_free_space  = head_res.free_space;

    // queue never holds more words than it has entries
    `AFRF_ASSERT_NOW(a_oq_bound, aclk, aresetn, 1'b1, cnt_reg <= (OQ_AW+1)'(afrf_pkg::OQ_DEPTH))
    // a data write never lands in the same cycle as a burst read
    `AFRF_ASSERT_NOW(a_no_rw_overlap, aclk, aresetn, ram_we, !ram_re)
    // the word marked last of a read burst means the burst is done
    `AFRF_ASSERT_NOW(a_last_ends_burst, aclk, aresetn, s1_valid_reg && s1_read_reg && s1_res_reg.last, !burst_active_reg)
    // a burst beat issued with room always reaches stage one as a read word
    `AFRF_ASSERT_NEXT(a_beat_reaches_s1, aclk, aresetn, burst_active_reg && issue_ok && !cfg_valid, s1_valid_reg && s1_read_reg)

endmodule

// File: tb/tb_audio_frame_ring_fifo.sv
// testbench for audio_frame_ring_fifo: directed grant cases, then random traffic over
// several ring capacities, each result word checked against an in-bench ring predictor
// depends on afrf_pkg and audio_frame_ring_fifo
`timescale 1ns / 1ps

module tb_audio_frame_ring_fifo;

    localparam int CAP_W     = afrf_pkg::CAP_W;
    localparam int COUNT_W   = afrf_pkg::COUNT_W;
    localparam int FRAME_W   = afrf_pkg::FRAME_W;
    localparam int LEVEL_W   = afrf_pkg::LEVEL_W;
    localparam int PTR_W     = afrf_pkg::PTR_W;
    localparam int DEPTH     = afrf_pkg::DEPTH;
    localparam int MAX_BURST = afrf_pkg::MAX_BURST;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 16;
    localparam int PHASE_BUDGET = 58;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data        = afrf_pkg::CAP_RESET;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [1:0]          s_kind          = afrf_pkg::KIND_FLUSH;
    logic [COUNT_W-1:0]  s_count         = '0;
    logic                s_allow_partial = 1'b0;
    logic [FRAME_W-1:0]  s_frame_in      = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [COUNT_W-1:0]  m_granted;
    logic [FRAME_W-1:0]  m_frame_out;
    logic                m_frame_valid;
    logic                m_last;
    logic [LEVEL_W-1:0]  m_fill_level;
    logic [LEVEL_W-1:0]  m_free_space;

    audio_frame_ring_fifo dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_count         (s_count),
        .s_allow_partial (s_allow_partial),
        .s_frame_in      (s_frame_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_frame_out     (m_frame_out),
        .m_frame_valid   (m_frame_valid),
        .m_last          (m_last),
        .m_fill_level    (m_fill_level),
        .m_free_space    (m_free_space)
    );

    // clock, 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state: capacity, pointers, pending grant, frame store
    logic [CAP_W-1:0]    ring_lg     = afrf_pkg::CAP_RESET;
    logic [PTR_W-1:0]    wr_ptr      = '0;
    logic [PTR_W-1:0]    rd_ptr      = '0;
    logic [COUNT_W-1:0]  pend_frames = '0;
    logic [FRAME_W-1:0]  ring_store [0:DEPTH-1];

    afrf_pkg::result_t due_words [$];
    int      mismatches  = 0;
    int      burst_left  = 0;
    int      quiet_cycles = 0;

    // receiver stall pattern
    int       rx_mode      = 0;
    int       rx_mode_left = 0;
    logic [3:0] rx_phase   = '0;

    function automatic logic [PTR_W-1:0] ring_mask();
        int lg;
        lg = ring_lg;
        if (lg < 1) lg = 1;
        if (lg > 10) lg = 10;
        return PTR_W'((1 << lg) - 1);
    endfunction

    function automatic int fill_frames();
        return int'((wr_ptr - rd_ptr) & ring_mask());
    endfunction

    function automatic int free_frames();
        return int'(ring_mask()) - fill_frames();
    endfunction

    // grant: saturate count, all or nothing unless partial allowed
    function automatic logic [COUNT_W-1:0] grant_frames(input int avail,
                                                        input logic [COUNT_W-1:0] count,
                                                        input logic partial);
        int want;
        want = int'(count);
        if (want > MAX_BURST) want = MAX_BURST;
        if (want == 0 || avail == 0) return '0;
        if (avail < want && !partial) return '0;
        return COUNT_W'((avail < want) ? avail : want);
    endfunction

    task automatic push_word(input logic [COUNT_W-1:0] granted, input logic [FRAME_W-1:0] frame,
                             input logic fvalid, input logic last);
        afrf_pkg::result_t r;
        r.granted     = granted;
        r.frame       = frame;
        r.frame_valid = fvalid;
        r.last        = last;
        r.fill_level  = LEVEL_W'(fill_frames());
        r.free_space  = LEVEL_W'(free_frames());
        due_words.push_back(r);
    endtask

    // expected result words for one accepted input word
    task automatic predict_ring(input afrf_pkg::kind_t kind, input logic [COUNT_W-1:0] count,
                                input logic partial, input logic [FRAME_W-1:0] frame);
        logic [PTR_W-1:0]   mask;
        logic [PTR_W-1:0]   rp;
        logic [COUNT_W-1:0] g;
        mask = ring_mask();
        case (kind)
            afrf_pkg::KIND_WR_REQ: begin
                g = grant_frames(free_frames(), count, partial);
                pend_frames = g;
                push_word(g, '0, 1'b0, 1'b1);
            end
            afrf_pkg::KIND_WR_DATA: begin
                if (pend_frames != 0) begin
                    ring_store[wr_ptr & mask] = frame;
                    wr_ptr = (wr_ptr + 1'b1) & mask;
                    pend_frames = pend_frames - 1'b1;
                end
                push_word('0, '0, 1'b0, 1'b1);
            end
            afrf_pkg::KIND_RD_REQ: begin
                g = grant_frames(fill_frames(), count, partial);
                if (g == 0) begin
                    push_word('0, '0, 1'b0, 1'b1);
                end else begin
                    rp = rd_ptr;
                    rd_ptr = (rd_ptr + PTR_W'(g)) & mask;
                    for (int i = 0; i < int'(g); i++)
                        push_word(g, ring_store[int'((rp + PTR_W'(i)) & mask)], 1'b1,
                                  (i + 1 == int'(g)));
                end
            end
            default: begin
                wr_ptr = '0;
                rd_ptr = '0;
                pend_frames = '0;
                push_word('0, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [FRAME_W-1:0] rand_frame();
        return {$urandom, $urandom};
    endfunction

    // mostly short requests, some up to a full burst, a few zero or above the burst limit
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 65) return COUNT_W'($urandom_range(1, 8));
        if (r < 88) return COUNT_W'($urandom_range(1, MAX_BURST));
        return COUNT_W'($urandom_range(MAX_BURST + 1, 127));
    endfunction

    // send one input word in bursts with random gaps, predict on acceptance
    task automatic send_word(input afrf_pkg::kind_t kind, input logic [COUNT_W-1:0] count,
                             input logic partial, input logic [FRAME_W-1:0] frame);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_count         <= count;
        s_allow_partial <= partial;
        s_frame_in      <= frame;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        predict_ring(kind, count, partial, frame);
    endtask

    // stop sending and wait until every expected word has come out
    task automatic settle_ring();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] lg);
        settle_ring();
        cfg_valid <= 1'b1;
        cfg_data  <= lg;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        ring_lg     = lg;
        wr_ptr      = '0;
        rd_ptr      = '0;
        pend_frames = '0;
    endtask

    // empty read, dropped data, zero and saturated grants, replaced grant, flush
    task automatic test_grant_rules();
        send_word(afrf_pkg::KIND_RD_REQ, 7'd5, 1'b1, '0);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd0, 1'b0, '1);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd0, 1'b1, '0);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd3, 1'b0, '1);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd127, 1'b1, '0);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd0, 1'b0, '1);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd64, 1'b0, 64'h0123_4567_89ab_cdef);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd1, 1'b1, 64'hfedc_ba98_7654_3210);
        send_word(afrf_pkg::KIND_RD_REQ, 7'd64, 1'b0, '0);
        send_word(afrf_pkg::KIND_RD_REQ, 7'd127, 1'b1, '1);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd100, 1'b1, '0);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd2, 1'b0, '0);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd0, 1'b0, 64'h8000_0000_0000_0001);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd0, 1'b0, 64'h7fff_ffff_ffff_fffe);
        send_word(afrf_pkg::KIND_FLUSH, 7'd127, 1'b1, '1);
        send_word(afrf_pkg::KIND_RD_REQ, 7'd1, 1'b1, '0);
    endtask

    // two-slot ring holding one frame: full and empty edges, pointer wrap
    task automatic test_one_frame_ring();
        set_capacity(4'd1);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd2, 1'b0, '0);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd2, 1'b1, '0);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd0, 1'b0, 64'hdead_beef_0bad_f00d);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd1, 1'b1, '0);
        send_word(afrf_pkg::KIND_RD_REQ, 7'd2, 1'b0, '0);
        send_word(afrf_pkg::KIND_RD_REQ, 7'd1, 1'b0, '0);
        send_word(afrf_pkg::KIND_WR_REQ, 7'd1, 1'b0, '0);
        send_word(afrf_pkg::KIND_WR_DATA, 7'd0, 1'b0, 64'h5555_aaaa_5555_aaaa);
        send_word(afrf_pkg::KIND_RD_REQ, 7'd1, 1'b1, '0);
    endtask

    // random write sequences, reads, flushes and stray data words
    task automatic run_stream(input int budget);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_word(afrf_pkg::KIND_WR_REQ, pick_count(), ($urandom_range(0, 3) != 0),
                          rand_frame());
                sent++;
                n = int'(pend_frames);
                // sometimes cut the sequence short
                if (n > 0 && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
                repeat (n) begin
                    send_word(afrf_pkg::KIND_WR_DATA, COUNT_W'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)), rand_frame());
                    sent++;
                end
                if ($urandom_range(0, 7) == 0) begin
                    send_word(afrf_pkg::KIND_WR_DATA, COUNT_W'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)), rand_frame());
                    sent++;
                end
            end else if (pick < 86) begin
                send_word(afrf_pkg::KIND_RD_REQ, pick_count(), ($urandom_range(0, 3) != 0),
                          rand_frame());
                sent++;
            end else if (pick < 91) begin
                send_word(afrf_pkg::KIND_FLUSH, COUNT_W'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), rand_frame());
                sent++;
            end else begin
                send_word(afrf_pkg::KIND_WR_DATA, COUNT_W'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), rand_frame());
                sent++;
            end
        end
    endtask

    // several capacities, clamped codes at both ends among them
    task automatic test_random_streams();
        logic [CAP_W-1:0] caps [7];
        caps = '{4'd3, 4'd0, 4'd15, 4'd2, 4'd1, CAP_W'($urandom_range(4, 9)), 4'd10};
        foreach (caps[i]) begin
            set_capacity(caps[i]);
            run_stream(PHASE_BUDGET);
        end
    endtask

    // receiver: stall mode picked at random, changed when its run ends
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(64, 256);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_phase <= rx_phase + 1'b1;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 9) < 7);
            2: m_ready <= (rx_phase[1:0] == 2'd0);
            default: m_ready <= (rx_phase >= 4'd11);
        endcase
    end

    // compare each result word with the oldest expected word
    always @(posedge aclk) begin
        afrf_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                flag_mismatch("unexpected word", 64'(m_frame_out), 64'(0));
            end else begin
                want = due_words.pop_front();
                if (m_granted !== want.granted)
                    flag_mismatch("granted", 64'(m_granted), 64'(want.granted));
                if (m_frame_out !== want.frame)
                    flag_mismatch("frame_out", m_frame_out, want.frame);
                if (m_frame_valid !== want.frame_valid)
                    flag_mismatch("frame_valid", 64'(m_frame_valid), 64'(want.frame_valid));
                if (m_last !== want.last)
                    flag_mismatch("last", 64'(m_last), 64'(want.last));
                if (m_fill_level !== want.fill_level)
                    flag_mismatch("fill_level", 64'(m_fill_level), 64'(want.fill_level));
                if (m_free_space !== want.free_space)
                    flag_mismatch("free_space", 64'(m_free_space), 64'(want.free_space));
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_grant_rules();
        test_one_frame_ring();
        test_random_streams();
        settle_ring();
        if (due_words.size() != 0)
            flag_mismatch("words never delivered", 64'(due_words.size()), 64'(0));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
